// ----- rtl/rtte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_pkg
// Widths, operation and register codes, and the timeout clamp shared by the
// retransmission timeout estimator.
// ----------------------------------------------------------------------------
package rtte_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned MsW      = 20;
  localparam int unsigned CountW   = 8;
  localparam int unsigned SrttW    = 24;
  localparam int unsigned DevW     = 23;
  localparam int unsigned EstW     = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  typedef logic [OpW-1:0]      opcode_t;
  typedef logic [MsW-1:0]      ms_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [SrttW-1:0]    srtt_t;
  typedef logic [DevW-1:0]     dev_t;
  typedef logic [EstW-1:0]     est_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // Operation codes
  localparam opcode_t OP_INIT       = 2'd0;
  localparam opcode_t OP_NEW_PACKET = 2'd1;
  localparam opcode_t OP_SAMPLE     = 2'd2;
  localparam opcode_t OP_TIMEOUT    = 2'd3;

  // Register indexes
  localparam cfg_idx_t REG_MIN_TIMEOUT     = 2'd0;
  localparam cfg_idx_t REG_MAX_TIMEOUT     = 2'd1;
  localparam cfg_idx_t REG_MAX_RETRANSMITS = 2'd2;

  // Reset and fixed values
  localparam ms_t    MIN_TIMEOUT_RST     = 20'd1000;
  localparam ms_t    MAX_TIMEOUT_RST     = 20'd60000;
  localparam count_t MAX_RETRANSMITS_RST = 8'd3;
  localparam dev_t   INIT_DEVIATION      = 23'd3000;
  localparam ms_t    TIMEOUT_RST         = 20'd3000;
  localparam ms_t    TIMEOUT_MAX         = 20'hFFFFF;
  localparam srtt_t  SRTT_MAX            = 24'hFFFFFF;
  localparam dev_t   DEV_MAX             = 23'h7FFFFF;
  localparam count_t COUNT_MAX           = 8'hFF;

  // Below min gives min; otherwise above max gives max.
  function automatic ms_t clamp_timeout(est_t v, ms_t lo, ms_t hi);
    ms_t res;
    if (v < {4'd0, lo}) begin
      res = lo;
    end else if (v > {4'd0, hi}) begin
      res = hi;
    end else begin
      res = v[MsW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/rtte_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_in_if
// Input channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface rtte_in_if;
  logic             valid;
  logic             ready;
  rtte_pkg::opcode_t opcode;
  rtte_pkg::ms_t     measured_ms;

  modport source (output valid, output opcode, output measured_ms, input ready);
  modport sink   (input valid, input opcode, input measured_ms, output ready);
endinterface

// ----- rtl/rtte_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_out_if
// Result channel: one timeout word per handshake.
// ----------------------------------------------------------------------------
interface rtte_out_if;
  logic              valid;
  logic              ready;
  rtte_pkg::ms_t     timeout_ms;
  logic              give_up;
  rtte_pkg::count_t  retransmit_count;

  modport source (output valid, output timeout_ms, output give_up,
                  output retransmit_count, input ready);
  modport sink   (input valid, input timeout_ms, input give_up,
                  input retransmit_count, output ready);
endinterface

// ----- rtl/rtte_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtte_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtte_cfg_if;
  logic                valid;
  logic                ready;
  rtte_pkg::cfg_idx_t  index;
  rtte_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rtt_estimator_rto_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_estimator_rto_top
// Retransmission timeout estimator: smoothed RTT (x8) and mean deviation
// (x4) updated per sample, clamped timeout, exponential backoff on timeout.
// ----------------------------------------------------------------------------
// Stages: a word is registered in the input stage, then in the result stage.
// Throughput: one word per cycle while the result channel is not stalled;
//   the estimator update is a single pass of adds, shifts and a clamp between
//   the input and result registers; the state registers update as a word leaves the input stage.
// Reset (synchronous, rst_n low): both stages empty, registers at their
//   reset values, estimators cleared, deviation 3000, timeout 3000.
// ----------------------------------------------------------------------------
module rtt_estimator_rto_top (
  input  logic      clk,
  input  logic      rst_n,
  rtte_in_if.sink   in_chan,
  rtte_out_if.source out_chan,
  rtte_cfg_if.sink  cfg_chan
);

  // Configuration registers
  rtte_pkg::ms_t    min_timeout_r;
  rtte_pkg::ms_t    max_timeout_r;
  rtte_pkg::count_t max_retransmits_r;

  // Estimator state
  rtte_pkg::srtt_t  srtt_r, srtt_nxt;
  rtte_pkg::dev_t   dev_r, dev_nxt;
  rtte_pkg::ms_t    timeout_r, timeout_nxt;
  rtte_pkg::count_t count_r, count_nxt;
  logic             give_up_nxt;

  // Input stage
  logic              in_valid_r;
  rtte_pkg::opcode_t op_r;
  rtte_pkg::ms_t     meas_r;

  // Result stage
  logic              out_valid_r;
  rtte_pkg::ms_t     out_timeout_r;
  logic              out_give_up_r;
  rtte_pkg::count_t  out_count_r;

  // Sample datapath
  logic [21:0]       delta;
  logic [21:0]       mag;
  logic [24:0]       srtt_sum;
  logic [24:0]       dev_sum;
  rtte_pkg::srtt_t   srtt_smp;
  rtte_pkg::dev_t    dev_smp;
  rtte_pkg::est_t    est_smp;
  logic [20:0]       doubled;

  logic advance;

  // Move a word into the result stage whenever that stage is free or drains.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.timeout_ms       = out_timeout_r;
  assign out_chan.give_up          = out_give_up_r;
  assign out_chan.retransmit_count = out_count_r;

  // Sample: srtt += m - srtt/8, dev += |m - srtt/8| - dev/4.
  always_comb begin
    delta    = {2'd0, meas_r} - {1'b0, srtt_r[rtte_pkg::SrttW-1:3]};
    mag      = delta[21] ? (22'd0 - delta) : delta;
    srtt_sum = {1'b0, srtt_r} - {4'd0, srtt_r[rtte_pkg::SrttW-1:3]} + {5'd0, meas_r};
    dev_sum  = {2'd0, dev_r} - {4'd0, dev_r[rtte_pkg::DevW-1:2]} + {3'd0, mag};
    srtt_smp = (srtt_sum > {1'b0, rtte_pkg::SRTT_MAX}) ? rtte_pkg::SRTT_MAX
                                                       : srtt_sum[rtte_pkg::SrttW-1:0];
    dev_smp  = (dev_sum > {2'd0, rtte_pkg::DEV_MAX}) ? rtte_pkg::DEV_MAX
                                                     : dev_sum[rtte_pkg::DevW-1:0];
    est_smp  = {3'd0, srtt_smp[rtte_pkg::SrttW-1:3]} + {1'b0, dev_smp};
    doubled  = {timeout_r, 1'b0};
  end

  // Operation decode
  always_comb begin
    srtt_nxt    = srtt_r;
    dev_nxt     = dev_r;
    timeout_nxt = timeout_r;
    count_nxt   = count_r;
    give_up_nxt = 1'b0;
    unique case (op_r)
      rtte_pkg::OP_INIT: begin
        srtt_nxt    = '0;
        dev_nxt     = rtte_pkg::INIT_DEVIATION;
        count_nxt   = '0;
        timeout_nxt = rtte_pkg::clamp_timeout({1'b0, rtte_pkg::INIT_DEVIATION},
                                              min_timeout_r, max_timeout_r);
      end
      rtte_pkg::OP_NEW_PACKET: begin
        count_nxt = '0;
      end
      rtte_pkg::OP_SAMPLE: begin
        srtt_nxt    = srtt_smp;
        dev_nxt     = dev_smp;
        timeout_nxt = rtte_pkg::clamp_timeout(est_smp, min_timeout_r, max_timeout_r);
      end
      rtte_pkg::OP_TIMEOUT: begin
        // Saturate the doubled timeout at the field range, not at max_timeout.
        timeout_nxt = doubled[20] ? rtte_pkg::TIMEOUT_MAX : doubled[19:0];
        count_nxt   = (count_r == rtte_pkg::COUNT_MAX) ? count_r : count_r + 8'd1;
        give_up_nxt = count_nxt > max_retransmits_r;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes; drop writes beyond the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_timeout_r     <= rtte_pkg::MIN_TIMEOUT_RST;
      max_timeout_r     <= rtte_pkg::MAX_TIMEOUT_RST;
      max_retransmits_r <= rtte_pkg::MAX_RETRANSMITS_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        rtte_pkg::REG_MIN_TIMEOUT:     min_timeout_r     <= cfg_chan.data;
        rtte_pkg::REG_MAX_TIMEOUT:     max_timeout_r     <= cfg_chan.data;
        rtte_pkg::REG_MAX_RETRANSMITS: max_retransmits_r <= cfg_chan.data[rtte_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Estimator state: commit as the word advances to the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r    <= '0;
      dev_r     <= rtte_pkg::INIT_DEVIATION;
      timeout_r <= rtte_pkg::TIMEOUT_RST;
      count_r   <= '0;
    end else if (advance) begin
      srtt_r    <= srtt_nxt;
      dev_r     <= dev_nxt;
      timeout_r <= timeout_nxt;
      count_r   <= count_nxt;
    end
  end

  // Input stage: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r   <= in_chan.opcode;
      meas_r <= in_chan.measured_ms;
    end
  end

  // Result stage: fill on advance, clear when taken and nothing follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_timeout_r <= timeout_nxt;
      out_give_up_r <= give_up_nxt;
      out_count_r   <= count_nxt;
    end
  end

endmodule
